// ===== hdl/hpsm_pkg.sv =====
// Package: shared types and constants for the hall position and stall monitor.
`timescale 1ns / 1ps

package hpsm_pkg;

    localparam int HALL_W     = 3;
    localparam int MODE_W     = 2;
    localparam int SAMPLE_W   = 12;
    localparam int POS_W      = 16;
    localparam int INTERVAL_W = 14;
    localparam int TIMER_W    = 16;
    localparam int TABLE_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int INTERVAL_MAX_DEFAULT = 10000;
    localparam int TIMER_MAX_DEFAULT    = 65000;

    localparam logic [TABLE_W-1:0]    FORWARD_TABLE_RESET  = 24'd1103256;
    localparam logic [TABLE_W-1:0]    REVERSE_TABLE_RESET  = 24'd680680;
    localparam logic [SAMPLE_W-1:0]   CURRENT_OFFSET_RESET = 12'd2048;
    localparam logic [TIMER_W-1:0]    STALL_LIMIT_RESET    = 16'd30000;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_HALL = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_STOPPED = 2'd2,
        MODE_OTHER   = 2'd3
    } t_run_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_TABLE  = 2'd0,
        CFG_REVERSE_TABLE  = 2'd1,
        CFG_CURRENT_OFFSET = 2'd2,
        CFG_STALL_LIMIT    = 2'd3
    } t_cfg_index;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                is_tick;
        logic [HALL_W-1:0]   hall_pins;
        t_run_mode           run_mode;
        logic                motor_reverse;
        logic                calibrated;
        logic [SAMPLE_W-1:0] current_corr;
        logic [SAMPLE_W-1:0] voltage;
        logic [SAMPLE_W-1:0] temp;
    } t_item;

    // Queue handshake between front and back.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_port;

    // new = floor(3/4 old) + floor(sample/4); never exceeds 12 bits.
    function automatic logic [SAMPLE_W-1:0] lowpass(
        input logic [SAMPLE_W-1:0] old_val,
        input logic [SAMPLE_W-1:0] sample
    );
        logic [SAMPLE_W+1:0] triple;
        logic [SAMPLE_W:0]   sum;
        begin
            triple = {2'b00, old_val} + {1'b0, old_val, 1'b0};
            sum    = {1'b0, triple[SAMPLE_W+1:2]} + {3'b000, sample[SAMPLE_W-1:2]};
            lowpass = sum[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/hpsm_front.sv =====
// Front stage: accepts input transfers and classifies them into queue items.
`timescale 1ns / 1ps

module hpsm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [hpsm_pkg::HALL_W-1:0]   i_hall_pins,
    input  logic [hpsm_pkg::MODE_W-1:0]   i_run_mode,
    input  logic                          i_motor_reverse,
    input  logic                          i_calibrated,
    input  logic [hpsm_pkg::SAMPLE_W-1:0] i_current_sample,
    input  logic [hpsm_pkg::SAMPLE_W-1:0] i_voltage_sample,
    input  logic [hpsm_pkg::SAMPLE_W-1:0] i_temp_sample,
    input  logic [hpsm_pkg::SAMPLE_W-1:0] i_current_offset,
    input  logic                          i_queue_full,
    output hpsm_pkg::t_queue_port         o_push
);
    import hpsm_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  push;
    logic  accept;

    assign push       = r_valid && !i_queue_full;
    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_item.is_tick       = (t_opcode'(i_opcode) == OP_TICK);
        n_item.hall_pins     = i_hall_pins;
        n_item.run_mode      = t_run_mode'(i_run_mode);
        n_item.motor_reverse = i_motor_reverse;
        n_item.calibrated    = i_calibrated;
        // offset minus sample, floored at zero
        n_item.current_corr  = (i_current_sample < i_current_offset) ?
                               (i_current_offset - i_current_sample) : '0;
        n_item.voltage       = i_voltage_sample;
        n_item.temp          = i_temp_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_push.valid = push;
    assign o_push.item  = r_item;

endmodule

// ===== hdl/hpsm_queue.sv =====
// Short queue that decouples the classifying front from the executing back.
`timescale 1ns / 1ps

module hpsm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hpsm_pkg::t_queue_port i_push,
    output logic                  o_full,
    input  logic                  i_pop,
    output hpsm_pkg::t_queue_port o_head
);
    import hpsm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/hpsm_back.sv =====
// Back stage: updates position, timers, filters and stall flags; holds the result register.
`timescale 1ns / 1ps

module hpsm_back #(
    parameter int INTERVAL_MAX = hpsm_pkg::INTERVAL_MAX_DEFAULT,
    parameter int TIMER_MAX    = hpsm_pkg::TIMER_MAX_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hpsm_pkg::t_queue_port           i_head,
    output logic                            o_pop,
    input  logic [hpsm_pkg::TABLE_W-1:0]    i_forward_table,
    input  logic [hpsm_pkg::TABLE_W-1:0]    i_reverse_table,
    input  logic [hpsm_pkg::TIMER_W-1:0]    i_stall_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [hpsm_pkg::POS_W-1:0] o_position,
    output logic                            o_sensor_fault,
    output logic                            o_forward_stall,
    output logic                            o_reverse_stall,
    output logic                            o_stall_status,
    output logic                            o_interval_valid,
    output logic [hpsm_pkg::INTERVAL_W-1:0] o_interval_ticks,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_current_filtered,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_voltage_filtered,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_temp_filtered
);
    import hpsm_pkg::*;

    // architectural state
    logic [HALL_W-1:0]       r_hall_latched,  n_hall_latched;
    logic [HALL_W-1:0]       r_hall_seen,     n_hall_seen;
    logic signed [POS_W-1:0] r_position,      n_position;
    logic                    r_fault,         n_fault;
    logic [INTERVAL_W-1:0]   r_interval,      n_interval;
    logic [TIMER_W-1:0]      r_timer,         n_timer;
    logic                    r_fwd_stall,     n_fwd_stall;
    logic                    r_rev_stall,     n_rev_stall;
    logic                    r_status,        n_status;
    logic [SAMPLE_W-1:0]     r_filt_cur,      n_filt_cur;
    logic [SAMPLE_W-1:0]     r_filt_volt,     n_filt_volt;
    logic [SAMPLE_W-1:0]     r_filt_temp,     n_filt_temp;
    logic                    n_ivalid;
    logic [INTERVAL_W-1:0]   n_iticks;

    // result register
    logic                    r_out_valid;
    logic                    r_out_ivalid;
    logic [INTERVAL_W-1:0]   r_out_iticks;

    t_item                   item;
    logic [HALL_W-1:0]       fwd_next;
    logic [HALL_W-1:0]       rev_next;

    assign item  = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    assign fwd_next = i_forward_table[3*r_hall_latched +: HALL_W];
    assign rev_next = i_reverse_table[3*r_hall_latched +: HALL_W];

    always_comb begin
        n_hall_latched = r_hall_latched;
        n_hall_seen    = r_hall_seen;
        n_position     = r_position;
        n_fault        = r_fault;
        n_interval     = r_interval;
        n_timer        = r_timer;
        n_fwd_stall    = r_fwd_stall;
        n_rev_stall    = r_rev_stall;
        n_status       = r_status;
        n_filt_cur     = r_filt_cur;
        n_filt_volt    = r_filt_volt;
        n_filt_temp    = r_filt_temp;
        n_ivalid       = 1'b0;
        n_iticks       = '0;

        if (!item.is_tick) begin
            // forward match wins when both tables agree
            if (item.hall_pins == fwd_next) begin
                n_position = r_position + 16'sd1;
                n_fault    = 1'b0;
            end else if (item.hall_pins == rev_next) begin
                n_position = r_position - 16'sd1;
                n_fault    = 1'b0;
            end else begin
                n_fault    = 1'b1;
            end
            n_hall_latched = item.hall_pins;
        end else begin
            if (r_interval < INTERVAL_W'(INTERVAL_MAX)) begin
                n_interval = r_interval + 1'b1;
            end
            n_filt_cur  = lowpass(r_filt_cur,  item.current_corr);
            n_filt_volt = lowpass(r_filt_volt, item.voltage);
            n_filt_temp = lowpass(r_filt_temp, item.temp);

            if (r_timer < TIMER_W'(TIMER_MAX)) begin
                n_timer = r_timer + 1'b1;
            end
            if (item.run_mode == MODE_STOPPED) begin
                n_timer = '0;
            end

            if (r_hall_seen != r_hall_latched) begin
                n_timer     = '0;
                n_hall_seen = r_hall_latched;
                n_ivalid    = 1'b1;
                n_iticks    = n_interval;
                n_interval  = '0;
            end

            if ((n_timer > i_stall_limit) && (item.run_mode == MODE_RUNNING)) begin
                if (item.motor_reverse) begin
                    n_rev_stall = 1'b1;
                end else begin
                    n_fwd_stall = 1'b1;
                end
                if (item.calibrated) begin
                    n_status = 1'b1;
                end
                n_timer = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hall_latched <= '0;
            r_hall_seen    <= '0;
            r_position     <= '0;
            r_fault        <= 1'b0;
            r_interval     <= '0;
            r_timer        <= '0;
            r_fwd_stall    <= 1'b0;
            r_rev_stall    <= 1'b0;
            r_status       <= 1'b0;
            r_filt_cur     <= '0;
            r_filt_volt    <= '0;
            r_filt_temp    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
            if (o_pop) begin
                r_hall_latched <= n_hall_latched;
                r_hall_seen    <= n_hall_seen;
                r_position     <= n_position;
                r_fault        <= n_fault;
                r_interval     <= n_interval;
                r_timer        <= n_timer;
                r_fwd_stall    <= n_fwd_stall;
                r_rev_stall    <= n_rev_stall;
                r_status       <= n_status;
                r_filt_cur     <= n_filt_cur;
                r_filt_volt    <= n_filt_volt;
                r_filt_temp    <= n_filt_temp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_ivalid <= n_ivalid;
            r_out_iticks <= n_iticks;
        end
    end

    // state registers double as the result payload; they only move on a pop
    assign o_out_valid        = r_out_valid;
    assign o_position         = r_position;
    assign o_sensor_fault     = r_fault;
    assign o_forward_stall    = r_fwd_stall;
    assign o_reverse_stall    = r_rev_stall;
    assign o_stall_status     = r_status;
    assign o_interval_valid   = r_out_ivalid;
    assign o_interval_ticks   = r_out_iticks;
    assign o_current_filtered = r_filt_cur;
    assign o_voltage_filtered = r_filt_volt;
    assign o_temp_filtered    = r_filt_temp;

endmodule

// ===== hdl/hall_position_stall_monitor_top.sv =====
// Top level: configuration registers and the front / queue / back chain.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
// a hall edge (opcode 0) or a control tick (opcode 1) with its samples.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item, in order: position, fault, sticky stall flags, interval, filters.
// From input transfer to result valid an item passes the front register, the
// queue, then the back stage that updates state and loads the result register.
// Throughput is one item per cycle while the receiver does not stall; the state
// update in the back stage is the loop that sets that figure.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, then the front register fills and o_in_stall rises; no item is lost.
// Synchronous reset clears all state and counters, restores the register
// defaults and empties the pipeline. Configuration writes (i_cfg_we,
// i_cfg_index, i_cfg_data) take effect at the next edge and belong in idle
// periods.
`timescale 1ns / 1ps

module hall_position_stall_monitor_top #(
    parameter int INTERVAL_MAX = hpsm_pkg::INTERVAL_MAX_DEFAULT,
    parameter int TIMER_MAX    = hpsm_pkg::TIMER_MAX_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hpsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [hpsm_pkg::HALL_W-1:0]     i_hall_pins,
    input  logic [hpsm_pkg::MODE_W-1:0]     i_run_mode,
    input  logic                            i_motor_reverse,
    input  logic                            i_calibrated,
    input  logic [hpsm_pkg::SAMPLE_W-1:0]   i_current_sample,
    input  logic [hpsm_pkg::SAMPLE_W-1:0]   i_voltage_sample,
    input  logic [hpsm_pkg::SAMPLE_W-1:0]   i_temp_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [hpsm_pkg::POS_W-1:0] o_position,
    output logic                            o_sensor_fault,
    output logic                            o_forward_stall,
    output logic                            o_reverse_stall,
    output logic                            o_stall_status,
    output logic                            o_interval_valid,
    output logic [hpsm_pkg::INTERVAL_W-1:0] o_interval_ticks,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_current_filtered,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_voltage_filtered,
    output logic [hpsm_pkg::SAMPLE_W-1:0]   o_temp_filtered
);
    import hpsm_pkg::*;

    logic [TABLE_W-1:0]  r_forward_table;
    logic [TABLE_W-1:0]  r_reverse_table;
    logic [SAMPLE_W-1:0] r_current_offset;
    logic [TIMER_W-1:0]  r_stall_limit;

    t_queue_port push;
    t_queue_port head;
    logic        queue_full;
    logic        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_table  <= FORWARD_TABLE_RESET;
            r_reverse_table  <= REVERSE_TABLE_RESET;
            r_current_offset <= CURRENT_OFFSET_RESET;
            r_stall_limit    <= STALL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FORWARD_TABLE:  r_forward_table  <= i_cfg_data[TABLE_W-1:0];
                CFG_REVERSE_TABLE:  r_reverse_table  <= i_cfg_data[TABLE_W-1:0];
                CFG_CURRENT_OFFSET: r_current_offset <= i_cfg_data[SAMPLE_W-1:0];
                CFG_STALL_LIMIT:    r_stall_limit    <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    hpsm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_hall_pins      (i_hall_pins),
        .i_run_mode       (i_run_mode),
        .i_motor_reverse  (i_motor_reverse),
        .i_calibrated     (i_calibrated),
        .i_current_sample (i_current_sample),
        .i_voltage_sample (i_voltage_sample),
        .i_temp_sample    (i_temp_sample),
        .i_current_offset (r_current_offset),
        .i_queue_full     (queue_full),
        .o_push           (push)
    );

    hpsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    hpsm_back #(
        .INTERVAL_MAX (INTERVAL_MAX),
        .TIMER_MAX    (TIMER_MAX)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .o_pop              (pop),
        .i_forward_table    (r_forward_table),
        .i_reverse_table    (r_reverse_table),
        .i_stall_limit      (r_stall_limit),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_position         (o_position),
        .o_sensor_fault     (o_sensor_fault),
        .o_forward_stall    (o_forward_stall),
        .o_reverse_stall    (o_reverse_stall),
        .o_stall_status     (o_stall_status),
        .o_interval_valid   (o_interval_valid),
        .o_interval_ticks   (o_interval_ticks),
        .o_current_filtered (o_current_filtered),
        .o_voltage_filtered (o_voltage_filtered),
        .o_temp_filtered    (o_temp_filtered)
    );

endmodule

// ===== hdl/hpsm_checker.sv =====
// Port-level checker for the monitor, bound to the top level.
`timescale 1ns / 1ps

module hpsm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic signed [hpsm_pkg::POS_W-1:0] o_position,
    input logic                            o_forward_stall,
    input logic                            o_reverse_stall,
    input logic                            o_stall_status,
    input logic                            o_interval_valid,
    input logic [hpsm_pkg::INTERVAL_W-1:0] o_interval_ticks
);
    import hpsm_pkg::*;

    // a stalled result holds until transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_position)
            && $stable(o_interval_ticks))
        else $error("stalled result changed");

    // interval field reads zero unless fresh
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_interval_valid |-> o_interval_ticks == '0)
        else $error("stale interval not zero");

    // stall flags are sticky; only the forward flag is checked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_forward_stall |=> o_forward_stall)
        else $error("forward stall flag dropped");

    // status never set without a direction flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stall_status |-> o_forward_stall || o_reverse_stall)
        else $error("stall status without direction flag");

endmodule

bind hall_position_stall_monitor_top hpsm_checker u_hpsm_checker (.*);

// ===== tb/tb_hall_position_stall_monitor_top.sv =====
// Self-checking testbench for the hall position and stall monitor top level.
`timescale 1ns / 1ps

module tb_hall_position_stall_monitor_top;
    import hpsm_pkg::*;

    localparam int INTERVAL_CAP = INTERVAL_MAX_DEFAULT;
    localparam int TIMER_CAP    = TIMER_MAX_DEFAULT;
    localparam int STALL_GUARD  = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int PRINT_CAP    = 100;
    localparam int N_DIRECTED   = 23;
    localparam int N_TYPED      = 5;
    localparam int WALK_STEPS   = 16;
    localparam int SHORT_LIMIT  = 20;

    typedef struct packed {
        t_opcode             op;
        logic [HALL_W-1:0]   pins;
        t_run_mode           mode;
        logic                rev;
        logic                cal;
        logic [SAMPLE_W-1:0] cur;
        logic [SAMPLE_W-1:0] volt;
        logic [SAMPLE_W-1:0] temp;
    } t_motor_item;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    fault;
        logic                    fwd_stall;
        logic                    rev_stall;
        logic                    status;
        logic                    ivalid;
        logic [INTERVAL_W-1:0]   iticks;
        logic [SAMPLE_W-1:0]     cur_f;
        logic [SAMPLE_W-1:0]     volt_f;
        logic [SAMPLE_W-1:0]     temp_f;
    } t_status;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data       = '0;
    logic                    i_in_valid       = 1'b0;
    logic                    i_opcode         = 1'b0;
    logic [HALL_W-1:0]       i_hall_pins      = '0;
    logic [MODE_W-1:0]       i_run_mode       = '0;
    logic                    i_motor_reverse  = 1'b0;
    logic                    i_calibrated     = 1'b0;
    logic [SAMPLE_W-1:0]     i_current_sample = '0;
    logic [SAMPLE_W-1:0]     i_voltage_sample = '0;
    logic [SAMPLE_W-1:0]     i_temp_sample    = '0;
    logic                    i_out_stall      = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [POS_W-1:0] o_position;
    logic                    o_sensor_fault;
    logic                    o_forward_stall;
    logic                    o_reverse_stall;
    logic                    o_stall_status;
    logic                    o_interval_valid;
    logic [INTERVAL_W-1:0]   o_interval_ticks;
    logic [SAMPLE_W-1:0]     o_current_filtered;
    logic [SAMPLE_W-1:0]     o_voltage_filtered;
    logic [SAMPLE_W-1:0]     o_temp_filtered;

    // Shadow registers and monitor state
    logic [TABLE_W-1:0]  fwd_tab      = FORWARD_TABLE_RESET;
    logic [TABLE_W-1:0]  rev_tab      = REVERSE_TABLE_RESET;
    logic [SAMPLE_W-1:0] cur_offset   = CURRENT_OFFSET_RESET;
    logic [TIMER_W-1:0]  stall_lim    = STALL_LIMIT_RESET;
    logic [HALL_W-1:0]   hall_now     = '0;
    logic [HALL_W-1:0]   hall_ticked  = '0;
    logic [POS_W-1:0]    pos_cnt      = '0;
    logic                fault_now    = 1'b0;
    int                  interval_cnt = 0;
    int                  stall_tmr    = 0;
    logic [2:0]          stall_sticky = '0;
    int                  filt [3]     = '{0, 0, 0};

    t_status status_expected_q [$];
    t_status no_typed      = '0;
    int      mismatch_cnt  = 0;
    int      idle_cycles   = 0;
    int      tx_idle_pct   = 0;
    int      rx_stall_pct  = 0;
    int      tick_burst    = 0;
    bit      rx_hold       = 1'b0;

    t_motor_item dir_stim [N_DIRECTED] = '{
        '{OP_TICK, 3'd7, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd0, MODE_OTHER,   1'b1, 1'b1, 12'd4095, 12'd4095, 12'd4095},
        '{OP_HALL, 3'd1, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_TICK, 3'd0, MODE_RUNNING, 1'b0, 1'b1, 12'd4095, 12'd4095, 12'd4095},
        '{OP_HALL, 3'd3, MODE_STOPPED, 1'b1, 1'b0, 12'd7,    12'd9,    12'd11},
        '{OP_HALL, 3'd1, MODE_RUNNING, 1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd5, MODE_IDLE,    1'b0, 1'b1, 12'd4095, 12'd0,    12'd4095},
        '{OP_HALL, 3'd4, MODE_OTHER,   1'b1, 1'b0, 12'd0,    12'd4095, 12'd0},
        '{OP_TICK, 3'd6, MODE_STOPPED, 1'b1, 1'b1, 12'd2047, 12'd1,    12'd2},
        '{OP_TICK, 3'd1, MODE_OTHER,   1'b0, 1'b1, 12'd2048, 12'd4095, 12'd0},
        '{OP_TICK, 3'd2, MODE_RUNNING, 1'b1, 1'b0, 12'd1,    12'd2048, 12'd4095},
        '{OP_HALL, 3'd7, MODE_IDLE,    1'b0, 1'b0, 12'd100,  12'd200,  12'd300},
        '{OP_HALL, 3'd0, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd0, MODE_RUNNING, 1'b1, 1'b1, 12'd0,    12'd0,    12'd0},
        '{OP_TICK, 3'd5, MODE_IDLE,    1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095},
        '{OP_HALL, 3'd6, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd4, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd5, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd1, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_HALL, 3'd2, MODE_IDLE,    1'b0, 1'b0, 12'd0,    12'd0,    12'd0},
        '{OP_TICK, 3'd2, MODE_RUNNING, 1'b0, 1'b1, 12'hAAA,  12'h555,  12'hFFF},
        '{OP_TICK, 3'd4, MODE_STOPPED, 1'b0, 1'b0, 12'h555,  12'hAAA,  12'd0},
        '{OP_TICK, 3'd3, MODE_OTHER,   1'b1, 1'b1, 12'd0,    12'd0,    12'd0}
    };

    // Results for the opening rows, worked out by hand from the reset tables
    t_status dir_typed [N_TYPED] = '{
        '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 12'd512, 12'd0, 12'd0},
        '{16'sd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 12'd512, 12'd0, 12'd0},
        '{16'sd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 12'd512, 12'd0, 12'd0},
        '{16'sd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 14'd2, 12'd384, 12'd1023, 12'd1023},
        '{16'sd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 14'd0, 12'd384, 12'd1023, 12'd1023}
    };

    hall_position_stall_monitor_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_hall_pins        (i_hall_pins),
        .i_run_mode         (i_run_mode),
        .i_motor_reverse    (i_motor_reverse),
        .i_calibrated       (i_calibrated),
        .i_current_sample   (i_current_sample),
        .i_voltage_sample   (i_voltage_sample),
        .i_temp_sample      (i_temp_sample),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_position         (o_position),
        .o_sensor_fault     (o_sensor_fault),
        .o_forward_stall    (o_forward_stall),
        .o_reverse_stall    (o_reverse_stall),
        .o_stall_status     (o_stall_status),
        .o_interval_valid   (o_interval_valid),
        .o_interval_ticks   (o_interval_ticks),
        .o_current_filtered (o_current_filtered),
        .o_voltage_filtered (o_voltage_filtered),
        .o_temp_filtered    (o_temp_filtered)
    );

    always #1 i_clk = ~i_clk;

    function automatic int smooth(input int old_val, input int sample);
        return (old_val * 3) / 4 + sample / 4;
    endfunction

    // Advances the monitor state by one item and returns the status it reports
    function automatic t_status step_monitor(input t_motor_item it);
        t_status r;
        int corr;
        r = '0;
        if (it.op == OP_HALL) begin
            if (it.pins == fwd_tab[3*hall_now +: 3]) begin
                pos_cnt++;
                fault_now = 1'b0;
            end else if (it.pins == rev_tab[3*hall_now +: 3]) begin
                pos_cnt--;
                fault_now = 1'b0;
            end else begin
                fault_now = 1'b1;
            end
            hall_now = it.pins;
        end else begin
            if (interval_cnt < INTERVAL_CAP)
                interval_cnt++;
            corr = (it.cur < cur_offset) ? int'(cur_offset) - int'(it.cur) : 0;
            filt[0] = smooth(filt[0], corr);
            filt[1] = smooth(filt[1], int'(it.volt));
            filt[2] = smooth(filt[2], int'(it.temp));
            if (stall_tmr < TIMER_CAP)
                stall_tmr++;
            if (it.mode == MODE_STOPPED)
                stall_tmr = 0;
            if (hall_ticked != hall_now) begin
                stall_tmr   = 0;
                hall_ticked = hall_now;
                r.ivalid    = 1'b1;
                r.iticks    = INTERVAL_W'(interval_cnt);
                interval_cnt = 0;
            end
            if (stall_tmr > int'(stall_lim) && it.mode == MODE_RUNNING) begin
                if (it.rev)
                    stall_sticky[1] = 1'b1;
                else
                    stall_sticky[0] = 1'b1;
                if (it.cal)
                    stall_sticky[2] = 1'b1;
                stall_tmr = 0;
            end
        end
        r.position  = pos_cnt;
        r.fault     = fault_now;
        r.fwd_stall = stall_sticky[0];
        r.rev_stall = stall_sticky[1];
        r.status    = stall_sticky[2];
        r.cur_f     = SAMPLE_W'(filt[0]);
        r.volt_f    = SAMPLE_W'(filt[1]);
        r.temp_f    = SAMPLE_W'(filt[2]);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly legal hall sequences and bursts of ticks, some noise edges
    function automatic t_motor_item random_item();
        t_motor_item it;
        int pick;
        it.op   = OP_TICK;
        it.pins = HALL_W'($urandom);
        it.mode = t_run_mode'($urandom_range(3));
        it.rev  = 1'($urandom);
        it.cal  = 1'($urandom);
        it.cur  = rand_sample();
        it.volt = rand_sample();
        it.temp = rand_sample();
        if (tick_burst == 0) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                tick_burst = $urandom_range(12, 1);
            end else begin
                it.op = OP_HALL;
                if (pick < 75)
                    it.pins = fwd_tab[3*hall_now +: 3];
                else if (pick < 88)
                    it.pins = rev_tab[3*hall_now +: 3];
                return it;
            end
        end
        tick_burst--;
        if ($urandom_range(1))
            it.mode = MODE_RUNNING;
        return it;
    endfunction

    function automatic void check_field(input string fld, input int want, input int got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= PRINT_CAP)
                $display("t=%0t %s: expected %0d, got %0d", $time, fld, want, got);
        end
    endfunction

    // Starts and ends on a falling edge; the caller drives valid at the end edge
    task automatic send_item(input t_motor_item it, input bit use_typed, input t_status typed);
        t_status r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= it.op;
        i_hall_pins      <= it.pins;
        i_run_mode       <= it.mode;
        i_motor_reverse  <= it.rev;
        i_calibrated     <= it.cal;
        i_current_sample <= it.cur;
        i_voltage_sample <= it.volt;
        i_temp_sample    <= it.temp;
        do @(posedge i_clk); while (o_in_stall);
        r = step_monitor(it);
        status_expected_q.push_back(use_typed ? typed : r);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_item(random_item(), 1'b0, no_typed);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (status_expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_FORWARD_TABLE:  fwd_tab    = val;
            CFG_REVERSE_TABLE:  rev_tab    = val;
            CFG_CURRENT_OFFSET: cur_offset = val[SAMPLE_W-1:0];
            CFG_STALL_LIMIT:    stall_lim  = val[TIMER_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_status want;
        t_status got;
        if (o_out_valid && !i_out_stall) begin
            got = '{o_position, o_sensor_fault, o_forward_stall, o_reverse_stall,
                    o_stall_status, o_interval_valid, o_interval_ticks,
                    o_current_filtered, o_voltage_filtered, o_temp_filtered};
            if (status_expected_q.size() == 0) begin
                mismatch_cnt++;
                $display("t=%0t unexpected transfer: expected none, got position %0d",
                         $time, got.position);
            end else begin
                want = status_expected_q.pop_front();
                check_field("position",         int'(want.position), int'(got.position));
                check_field("sensor_fault",     int'(want.fault),     int'(got.fault));
                check_field("forward_stall",    int'(want.fwd_stall), int'(got.fwd_stall));
                check_field("reverse_stall",    int'(want.rev_stall), int'(got.rev_stall));
                check_field("stall_status",     int'(want.status),    int'(got.status));
                check_field("interval_valid",   int'(want.ivalid),    int'(got.ivalid));
                check_field("interval_ticks",   int'(want.iticks),    int'(got.iticks));
                check_field("current_filtered", int'(want.cur_f),     int'(got.cur_f));
                check_field("voltage_filtered", int'(want.volt_f),    int'(got.volt_f));
                check_field("temp_filtered",    int'(want.temp_f),    int'(got.temp_f));
            end
        end
    end

    // Ends a hung run: too many cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_GUARD) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_motor_item it;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_stim[k]) begin
            if (k < N_TYPED)
                send_item(dir_stim[k], 1'b1, dir_typed[k]);
            else
                send_item(dir_stim[k], 1'b0, no_typed);
        end
        wait_for_results();

        // Stretch with no hall change: the stall timer climbs past a short
        // limit while not running, then a running tick trips it.
        write_reg(CFG_STALL_LIMIT, CFG_DATA_W'(SHORT_LIMIT));
        repeat (SHORT_LIMIT + 10) begin
            it      = random_item();
            it.op   = OP_TICK;
            it.mode = $urandom_range(1) ? MODE_IDLE : MODE_OTHER;
            send_item(it, 1'b0, no_typed);
        end
        it      = random_item();
        it.op   = OP_TICK;
        it.mode = MODE_RUNNING;
        it.rev  = 1'b0;
        it.cal  = 1'b0;
        send_item(it, 1'b0, no_typed);

        // Step into the six-state cycle, walk backward through zero,
        // then forward again.
        it      = random_item();
        it.op   = OP_HALL;
        it.pins = 3'd1;
        send_item(it, 1'b0, no_typed);
        repeat (WALK_STEPS) begin
            it      = random_item();
            it.op   = OP_HALL;
            it.pins = rev_tab[3*hall_now +: 3];
            send_item(it, 1'b0, no_typed);
        end
        repeat (6) begin
            it      = random_item();
            it.op   = OP_HALL;
            it.pins = fwd_tab[3*hall_now +: 3];
            send_item(it, 1'b0, no_typed);
        end
        it      = random_item();
        it.op   = OP_TICK;
        it.mode = MODE_IDLE;
        send_item(it, 1'b0, no_typed);
        wait_for_results();

        write_reg(CFG_CURRENT_OFFSET, 24'd4095);
        write_reg(CFG_STALL_LIMIT, 24'd3);
        run_random(130);
        wait_for_results();

        write_reg(CFG_FORWARD_TABLE, 24'hFFFFFF);
        write_reg(CFG_REVERSE_TABLE, 24'h000000);
        write_reg(CFG_CURRENT_OFFSET, 24'd0);
        write_reg(CFG_STALL_LIMIT, 24'd1);
        tx_idle_pct = 55;
        run_random(130);
        wait_for_results();

        // Limit of zero: any running tick with a nonzero timer stalls
        write_reg(CFG_FORWARD_TABLE, CFG_DATA_W'($urandom));
        write_reg(CFG_REVERSE_TABLE, CFG_DATA_W'($urandom));
        write_reg(CFG_STALL_LIMIT, 24'd0);
        tx_idle_pct  = 0;
        rx_stall_pct = 55;
        run_random(130);
        wait_for_results();

        // Upper data bits beyond each register's width are dropped
        write_reg(CFG_FORWARD_TABLE, FORWARD_TABLE_RESET);
        write_reg(CFG_REVERSE_TABLE, REVERSE_TABLE_RESET);
        write_reg(CFG_CURRENT_OFFSET, 24'hFFF800);
        write_reg(CFG_STALL_LIMIT, 24'hA50005);
        tx_idle_pct  = 8;
        rx_stall_pct = 8;
        run_random(130);
        wait_for_results();

        // Receiver holds off while items keep coming, so the input backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 1'b1;
        run_random(150);
        wait_for_results();

        write_reg(CFG_FORWARD_TABLE, CFG_DATA_W'($urandom));
        write_reg(CFG_REVERSE_TABLE, 24'hFFFFFF);
        write_reg(CFG_CURRENT_OFFSET, CFG_DATA_W'($urandom_range(4095)));
        write_reg(CFG_STALL_LIMIT, CFG_DATA_W'(TIMER_CAP));
        run_random(130);
        wait_for_results();

        if (mismatch_cnt == 0 && status_expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hpsm_pkg.sv
hdl/hpsm_front.sv
hdl/hpsm_queue.sv
hdl/hpsm_back.sv
hdl/hall_position_stall_monitor_top.sv
hdl/hpsm_checker.sv
tb/tb_hall_position_stall_monitor_top.sv
